// ===== src/mfs_pkg.sv =====
// Shared types and constants for the multilevel feedback scheduler.
package mfs_pkg;

    localparam int MAX_JOBS   = 64;
    localparam int MAX_LEVELS = 4;
    localparam int JOB_W      = 6;
    localparam int LVL_W      = 2;
    localparam int NL_W       = 3;
    localparam int CNT_W      = 7;
    localparam int TIME_W     = 32;
    localparam int WORK_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NUM_LEVELS   = 3'd0,
        REG_BOOST_PERIOD = 3'd1,
        REG_ALLOT0       = 3'd2,
        REG_ALLOT1       = 3'd3,
        REG_ALLOT2       = 3'd4,
        REG_ALLOT3       = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_BOOST
    } t_state;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_ARRIVE = 1'b1
    } t_op;

    typedef struct packed {
        logic [WORK_W-1:0] work_left;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] first_delay;
        logic              has_run;
        logic [WORK_W-1:0] usage;
    } t_job;

endpackage

// ===== src/multilevel_feedback_scheduler.sv =====
// Multilevel feedback queue scheduler: job records and run queues kept in memory.
//
// An arrival is handled in the idle state and gives no result. A tick that finds no ready
// job gives a registered result; a tick that runs a job reads the job record, then
// updates it and writes it back in the execute state, and its result is registered.
// When the boost period expires, a boost state follows that splices the lower levels
// one at a time onto level zero through the link memory. busy is high while a tick is in
// progress; the result is held on the outputs for one cycle, marked by o_valid,
// and cannot be stalled.
module multilevel_feedback_scheduler (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_op,
    input  logic [mfs_pkg::JOB_W-1:0]         i_job_id,
    input  logic [mfs_pkg::WORK_W-1:0]        i_work_amount,
    input  logic                              i_cfg_we,
    input  logic [mfs_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [mfs_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                              o_valid,
    output logic                              o_idle,
    output logic [mfs_pkg::LVL_W-1:0]         o_level_ran,
    output logic [mfs_pkg::JOB_W-1:0]         o_ran_job,
    output logic                              o_finished,
    output logic [mfs_pkg::TIME_W-1:0]        o_response_time,
    output logic [mfs_pkg::TIME_W-1:0]        o_turnaround_time
);
    import mfs_pkg::*;

    t_state r_state, n_state;

    logic [NL_W-1:0]   r_num_levels;
    logic [WORK_W-1:0] r_boost_period;
    logic [WORK_W-1:0] r_allot [MAX_LEVELS];

    logic [TIME_W-1:0] r_time, n_time;
    logic [WORK_W-1:0] r_boost_cnt, n_boost_cnt;
    logic [JOB_W-1:0]  r_head [MAX_LEVELS];
    logic [JOB_W-1:0]  n_head [MAX_LEVELS];
    logic [JOB_W-1:0]  r_tail [MAX_LEVELS];
    logic [JOB_W-1:0]  n_tail [MAX_LEVELS];
    logic [CNT_W-1:0]  r_count [MAX_LEVELS];
    logic [CNT_W-1:0]  n_count [MAX_LEVELS];
    logic [MAX_JOBS-1:0] r_queued, n_queued;

    logic [LVL_W-1:0]  r_lvl, n_lvl;
    logic [JOB_W-1:0]  r_job, n_job;
    logic [LVL_W-1:0]  r_bidx, n_bidx;

    // Job record and link memories with registered read ports.
    t_job              r_job_mem  [MAX_JOBS];
    logic [JOB_W-1:0]  r_link_mem [MAX_JOBS];
    t_job              r_rd_job;
    logic [JOB_W-1:0]  r_rd_link;
    logic              job_we, link_we, rd_en;
    logic [JOB_W-1:0]  job_wa, link_wa, link_wd, rd_addr;
    t_job              job_wd;

    logic              n_valid, n_idle, n_finished;
    logic [LVL_W-1:0]  n_level_ran;
    logic [JOB_W-1:0]  n_ran_job;
    logic [TIME_W-1:0] n_resp, n_turn;

    logic [NL_W-1:0]   nl;
    logic              found;
    logic [LVL_W-1:0]  hit_lvl;

    // Working values for the tick update.
    t_job              upd;
    logic              fin, demote;
    logic [LVL_W-1:0]  dest;
    logic [WORK_W:0]   boost_next;

    always_comb begin
        if (r_num_levels == '0) begin
            nl = NL_W'(1);
        end else if (r_num_levels > NL_W'(MAX_LEVELS)) begin
            nl = NL_W'(MAX_LEVELS);
        end else begin
            nl = r_num_levels;
        end
        found   = 1'b0;
        hit_lvl = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
            if (NL_W'(i) < nl && r_count[i] != '0) begin
                found   = 1'b1;
                hit_lvl = LVL_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_levels   <= NL_W'(4);
            r_boost_period <= WORK_W'(100);
            r_allot[0]     <= WORK_W'(4);
            r_allot[1]     <= WORK_W'(8);
            r_allot[2]     <= WORK_W'(16);
            r_allot[3]     <= WORK_W'(32);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_LEVELS:   r_num_levels   <= i_cfg_data[NL_W-1:0];
                REG_BOOST_PERIOD: r_boost_period <= i_cfg_data;
                REG_ALLOT0:       r_allot[0]     <= i_cfg_data;
                REG_ALLOT1:       r_allot[1]     <= i_cfg_data;
                REG_ALLOT2:       r_allot[2]     <= i_cfg_data;
                REG_ALLOT3:       r_allot[3]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (job_we) begin
            r_job_mem[job_wa] <= job_wd;
        end
        if (link_we) begin
            r_link_mem[link_wa] <= link_wd;
        end
        if (rd_en) begin
            r_rd_job  <= r_job_mem[rd_addr];
            r_rd_link <= r_link_mem[rd_addr];
        end
    end

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_boost_cnt = r_boost_cnt;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_queued    = r_queued;
        n_lvl       = r_lvl;
        n_job       = r_job;
        n_bidx      = r_bidx;
        job_we      = 1'b0;
        job_wa      = r_job;
        job_wd      = r_rd_job;
        link_we     = 1'b0;
        link_wa     = r_tail[0];
        link_wd     = r_job;
        rd_en       = 1'b0;
        rd_addr     = r_head[hit_lvl];
        n_valid     = 1'b0;
        n_idle      = 1'b0;
        n_finished  = 1'b0;
        n_level_ran = '0;
        n_ran_job   = '0;
        n_resp      = '0;
        n_turn      = '0;
        upd         = r_rd_job;
        fin         = 1'b0;
        demote      = 1'b0;
        dest        = r_lvl;
        boost_next  = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_ARRIVE) begin
                        if (!r_queued[i_job_id]) begin
                            job_we   = 1'b1;
                            job_wa   = i_job_id;
                            job_wd   = '{work_left: i_work_amount, arrival: r_time,
                                         first_delay: '0, has_run: 1'b0, usage: '0};
                            if (r_count[0] != '0) begin
                                link_we = 1'b1;
                                link_wa = r_tail[0];
                                link_wd = i_job_id;
                            end else begin
                                n_head[0] = i_job_id;
                            end
                            n_tail[0]           = i_job_id;
                            n_count[0]          = r_count[0] + CNT_W'(1);
                            n_queued[i_job_id]  = 1'b1;
                        end
                    end else if (!found) begin
                        n_valid = 1'b1;
                        n_idle  = 1'b1;
                    end else begin
                        rd_en   = 1'b1;
                        n_lvl   = hit_lvl;
                        n_job   = r_head[hit_lvl];
                        n_state = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                // Pop the head of the level it ran from.
                n_count[r_lvl] = r_count[r_lvl] - CNT_W'(1);
                if (n_count[r_lvl] == '0) begin
                    n_head[r_lvl] = '0;
                    n_tail[r_lvl] = '0;
                end else begin
                    n_head[r_lvl] = r_rd_link;
                end
                if (!r_rd_job.has_run) begin
                    upd.first_delay = r_time - r_rd_job.arrival;
                    upd.has_run     = 1'b1;
                end
                upd.work_left = r_rd_job.work_left - WORK_W'(1);
                if (r_rd_job.usage != '1) begin
                    upd.usage = r_rd_job.usage + WORK_W'(1);
                end
                fin = (upd.work_left == '0);
                n_valid     = 1'b1;
                n_level_ran = r_lvl;
                n_ran_job   = r_job;
                if (fin) begin
                    n_finished     = 1'b1;
                    n_resp         = upd.first_delay;
                    n_turn         = r_time + TIME_W'(1) - r_rd_job.arrival;
                    n_queued[r_job] = 1'b0;
                end else begin
                    demote = (upd.usage >= r_allot[r_lvl]) &&
                             ((NL_W'(r_lvl) + NL_W'(1)) < nl);
                    if (demote) begin
                        upd.usage = '0;
                        dest      = r_lvl + LVL_W'(1);
                    end
                    if (n_count[dest] != '0) begin
                        link_we = 1'b1;
                        link_wa = n_tail[dest];
                        link_wd = r_job;
                    end else begin
                        n_head[dest] = r_job;
                    end
                    n_tail[dest]  = r_job;
                    n_count[dest] = n_count[dest] + CNT_W'(1);
                end
                job_we = 1'b1;
                job_wa = r_job;
                job_wd = upd;
                n_time = r_time + TIME_W'(1);
                boost_next = {1'b0, r_boost_cnt} + (WORK_W+1)'(1);
                if (boost_next >= {1'b0, r_boost_period}) begin
                    n_boost_cnt = '0;
                    n_bidx      = LVL_W'(1);
                    n_state     = (MAX_LEVELS > 1) ? S_BOOST : S_IDLE;
                end else begin
                    n_boost_cnt = boost_next[WORK_W-1:0];
                    n_state     = S_IDLE;
                end
            end
            S_BOOST: begin
                // Splice one lower level onto the tail of level zero each cycle.
                if (NL_W'(r_bidx) < nl && r_count[r_bidx] != '0) begin
                    if (r_count[0] == '0) begin
                        n_head[0] = r_head[r_bidx];
                    end else begin
                        link_we = 1'b1;
                        link_wa = r_tail[0];
                        link_wd = r_head[r_bidx];
                    end
                    n_tail[0]       = r_tail[r_bidx];
                    n_count[0]      = r_count[0] + r_count[r_bidx];
                    n_count[r_bidx] = '0;
                    n_head[r_bidx]  = '0;
                    n_tail[r_bidx]  = '0;
                end
                n_bidx = r_bidx + LVL_W'(1);
                if (r_bidx == LVL_W'(MAX_LEVELS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_time      <= '0;
            r_boost_cnt <= '0;
            r_queued    <= '0;
            r_lvl       <= '0;
            r_job       <= '0;
            r_bidx      <= '0;
            o_valid     <= 1'b0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_tail[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_time      <= n_time;
            r_boost_cnt <= n_boost_cnt;
            r_queued    <= n_queued;
            r_lvl       <= n_lvl;
            r_job       <= n_job;
            r_bidx      <= n_bidx;
            o_valid     <= n_valid;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        o_idle            <= n_idle;
        o_level_ran       <= n_level_ran;
        o_ran_job         <= n_ran_job;
        o_finished        <= n_finished;
        o_response_time   <= n_resp;
        o_turnaround_time <= n_turn;
    end

    assign o_busy = (r_state != S_IDLE);

`ifndef SYNTHESIS
    a_exec_gives_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EXEC |=> o_valid)
        else $error("tick execution produced no result beat");

    a_jobs_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({2'b0, r_count[0]} + {2'b0, r_count[1]} + {2'b0, r_count[2]}
         + {2'b0, r_count[3]}) <= (CNT_W+2)'($countones(r_queued)))
        else $error("queued job total exceeds queued flags");

    a_idle_not_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_idle |-> !o_finished && o_ran_job == '0)
        else $error("idle beat carries a job");
`endif

endmodule

// ===== tb/multilevel_feedback_scheduler_tb.sv =====
// Self-checking testbench for the multilevel feedback queue scheduler.
`timescale 1ns / 1ps

module multilevel_feedback_scheduler_tb;
    import mfs_pkg::*;

    typedef struct {
        logic        idle;
        logic [1:0]  level;
        logic [5:0]  job;
        logic        finished;
        logic [31:0] response;
        logic [31:0] turnaround;
    } t_tick_result;

    class sched_scoreboard;
        logic [2:0]  num_levels;
        logic [15:0] boost_period;
        logic [15:0] allot[4];
        logic [31:0] now;
        logic [15:0] boost_cnt;
        logic [15:0] work_left[MAX_JOBS];
        logic [31:0] arrived_at[MAX_JOBS];
        logic [31:0] first_delay[MAX_JOBS];
        bit          ran_once[MAX_JOBS];
        logic [15:0] usage[MAX_JOBS];
        logic [5:0]  link[MAX_JOBS];
        bit          waiting[MAX_JOBS];
        logic [5:0]  head[4];
        logic [5:0]  tail[4];
        int          count[4];
        int          n_waiting;
        t_tick_result pending[$];
        int          errors;

        function new();
            num_levels = 4;
            boost_period = 100;
            allot[0] = 4; allot[1] = 8; allot[2] = 16; allot[3] = 32;
            now = 0;
            boost_cnt = 0;
            n_waiting = 0;
            errors = 0;
            for (int i = 0; i < MAX_JOBS; i++) begin
                waiting[i] = 0;
                link[i] = 0;
            end
            for (int l = 0; l < 4; l++) begin
                head[l] = 0; tail[l] = 0; count[l] = 0;
            end
        endfunction

        function void write_reg(t_cfg_idx idx, logic [15:0] value);
            case (idx)
                REG_NUM_LEVELS:   num_levels = value[2:0];
                REG_BOOST_PERIOD: boost_period = value;
                REG_ALLOT0:       allot[0] = value;
                REG_ALLOT1:       allot[1] = value;
                REG_ALLOT2:       allot[2] = value;
                REG_ALLOT3:       allot[3] = value;
                default: ;
            endcase
        endfunction

        function void push(int lv, logic [5:0] j);
            link[j] = 0;
            if (count[lv] == 0) head[lv] = j;
            else link[tail[lv]] = j;
            tail[lv] = j;
            count[lv]++;
        endfunction

        // Notes one accepted beat and queues the tick result it causes.
        function void note_input(t_op op, logic [5:0] id, logic [15:0] work);
            t_tick_result r;
            int nl;
            int h;
            logic [5:0] j;
            logic [16:0] c;
            if (op == OP_ARRIVE) begin
                if (waiting[id]) return;
                work_left[id] = work;
                arrived_at[id] = now;
                first_delay[id] = 0;
                ran_once[id] = 0;
                usage[id] = 0;
                waiting[id] = 1;
                n_waiting++;
                push(0, id);
                return;
            end
            r = '{idle: 0, level: 0, job: 0, finished: 0, response: 0, turnaround: 0};
            nl = num_levels;
            if (nl < 1) nl = 1;
            if (nl > MAX_LEVELS) nl = MAX_LEVELS;
            h = 0;
            while (h < nl && count[h] == 0) h++;
            if (h >= nl) begin
                r.idle = 1;
                pending.push_back(r);
                return;
            end
            j = head[h];
            count[h]--;
            head[h] = (count[h] == 0) ? 6'd0 : link[j];
            if (count[h] == 0) tail[h] = 0;
            link[j] = 0;
            if (!ran_once[j]) begin
                first_delay[j] = now - arrived_at[j];
                ran_once[j] = 1;
            end
            work_left[j] = work_left[j] - 16'd1;
            if (usage[j] != 16'hFFFF) usage[j]++;
            r.level = h[1:0];
            r.job = j;
            if (work_left[j] == 0) begin
                waiting[j] = 0;
                n_waiting--;
                r.finished = 1;
                r.response = first_delay[j];
                r.turnaround = now + 32'd1 - arrived_at[j];
            end else if (usage[j] >= allot[h] && h + 1 < nl) begin
                usage[j] = 0;
                push(h + 1, j);
            end else begin
                push(h, j);
            end
            now++;
            c = {1'b0, boost_cnt} + 17'd1;
            if (c >= {1'b0, boost_period}) begin
                boost_cnt = 0;
                // Lower levels are spliced onto level zero in level order.
                for (int i = 1; i < nl; i++) begin
                    if (count[i] != 0) begin
                        if (count[0] == 0) head[0] = head[i];
                        else link[tail[0]] = head[i];
                        tail[0] = tail[i];
                        count[0] += count[i];
                        count[i] = 0; head[i] = 0; tail[i] = 0;
                    end
                end
            end else begin
                boost_cnt = c[15:0];
            end
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH @%0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(t_tick_result got);
            t_tick_result w;
            if (pending.size() == 0) begin
                report($sformatf("unexpected result job %0d", got.job));
                return;
            end
            w = pending.pop_front();
            if (got.idle !== w.idle)
                report($sformatf("idle %0b want %0b", got.idle, w.idle));
            if (got.level !== w.level)
                report($sformatf("level_ran %0d want %0d", got.level, w.level));
            if (got.job !== w.job)
                report($sformatf("ran_job %0d want %0d", got.job, w.job));
            if (got.finished !== w.finished)
                report($sformatf("finished %0b want %0b", got.finished, w.finished));
            if (got.response !== w.response)
                report($sformatf("response_time %0d want %0d", got.response, w.response));
            if (got.turnaround !== w.turnaround)
                report($sformatf("turnaround_time %0d want %0d",
                                 got.turnaround, w.turnaround));
        endtask
    endclass

    logic                  i_clk = 0;
    logic                  i_rst_n = 0;
    logic                  i_start = 0;
    logic                  o_busy;
    logic                  i_op = 0;
    logic [JOB_W-1:0]      i_job_id = 0;
    logic [WORK_W-1:0]     i_work_amount = 0;
    logic                  i_cfg_we = 0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;
    logic                  o_valid;
    logic                  o_idle;
    logic [LVL_W-1:0]      o_level_ran;
    logic [JOB_W-1:0]      o_ran_job;
    logic                  o_finished;
    logic [TIME_W-1:0]     o_response_time;
    logic [TIME_W-1:0]     o_turnaround_time;

    sched_scoreboard sb = new();
    int beats;

    multilevel_feedback_scheduler DUT (.*);

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result('{idle: o_idle, level: o_level_ran, job: o_ran_job,
                              finished: o_finished, response: o_response_time,
                              turnaround: o_turnaround_time});
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_work();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 12);
        if (r < 97) return $urandom_range(13, 200);
        return $urandom_range(0, 65535);
    endfunction

    // Presents one beat, holding start high until the block takes it.
    task send_beat(t_op op, logic [5:0] id, logic [15:0] work, int gap);
        bit taken;
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1;
        i_op <= op;
        i_job_id <= id;
        i_work_amount <= work;
        do begin
            @(negedge i_clk);
            taken = !o_busy;
            @(posedge i_clk);
        end while (!taken);
        sb.note_input(op, id, work);
        beats++;
    endtask

    task drain();
        i_start <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task write_reg(t_cfg_idx idx, logic [15:0] value);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.write_reg(idx, value);
        @(posedge i_clk);
    endtask

    task random_phase(int n);
        bit arrive;
        logic [5:0] id;
        beats = 0;
        while (beats < n) begin
            arrive = ($urandom_range(0, 99) < ((sb.n_waiting < 8) ? 60 : 25));
            if (arrive) begin
                id = $urandom_range(0, 63);
                if (sb.waiting[id] && $urandom_range(0, 9) != 0) continue;
                send_beat(OP_ARRIVE, id, pick_work(), pick_gap());
            end else begin
                send_beat(OP_TICK, $urandom_range(0, 63), $urandom_range(0, 65535),
                          pick_gap());
            end
        end
        drain();
    endtask

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        repeat (2) @(posedge i_clk);

        // Directed: idle tick, field extremes, duplicate arrival, zero work.
        send_beat(OP_TICK, 0, 0, 0);
        send_beat(OP_ARRIVE, 0, 1, 0);
        send_beat(OP_ARRIVE, 63, 16'hFFFF, 0);
        send_beat(OP_ARRIVE, 63, 5, 1);
        send_beat(OP_ARRIVE, 21, 0, 0);
        send_beat(OP_ARRIVE, 42, 16'hAAAA, 0);
        send_beat(OP_ARRIVE, 10, 6, 0);
        repeat (16) send_beat(OP_TICK, 6'h3F, 16'hFFFF, $urandom_range(0, 2));
        drain();

        random_phase(300);

        write_reg(REG_NUM_LEVELS, 1);
        write_reg(REG_BOOST_PERIOD, 16'hFFFF);
        write_reg(REG_ALLOT0, 0);
        random_phase(200);

        write_reg(REG_NUM_LEVELS, 4);
        write_reg(REG_BOOST_PERIOD, 0);
        write_reg(REG_ALLOT0, 1);
        write_reg(REG_ALLOT1, 0);
        write_reg(REG_ALLOT2, 16'hFFFF);
        write_reg(REG_ALLOT3, 1);
        random_phase(250);

        write_reg(REG_NUM_LEVELS, 0);
        write_reg(REG_BOOST_PERIOD, 1);
        random_phase(150);

        write_reg(REG_NUM_LEVELS, 7);
        write_reg(REG_BOOST_PERIOD, $urandom_range(5, 60));
        write_reg(REG_ALLOT0, $urandom_range(1, 6));
        write_reg(REG_ALLOT1, $urandom_range(1, 10));
        write_reg(REG_ALLOT2, $urandom_range(0, 65535));
        write_reg(REG_ALLOT3, 16'h5555);
        random_phase(300);

        // Lowering the level count strands jobs on the higher levels until it is raised past them.
        write_reg(REG_NUM_LEVELS, 2);
        write_reg(REG_BOOST_PERIOD, 16'h8000);
        random_phase(150);

        write_reg(REG_NUM_LEVELS, 3);
        write_reg(REG_BOOST_PERIOD, $urandom_range(2, 30));
        write_reg(REG_ALLOT0, $urandom_range(1, 4));
        write_reg(REG_ALLOT1, $urandom_range(1, 4));
        random_phase(200);

        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
